// ===== rtl/smcp_pkg.sv =====
// Shared types and constants for the serial motor command parser.
// No dependencies.
`timescale 1ns / 1ps

package smcp_pkg;

    localparam int MAX_CHANNELS     = 4;
    localparam int DEFAULT_CHANNELS = 4;
    localparam int CH_W             = 2;
    localparam int DUTY_W           = 10;
    localparam int TICK_W           = 16;
    localparam int SPEED_W          = 8;
    localparam int PROD_W           = DUTY_W + SPEED_W;
    localparam int MASK_W           = 2 * MAX_CHANNELS;

    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = 10'd480;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET    = 16'd524;

    // APB map: register index sits in address bit 2
    localparam int               APB_ADDR_W    = 3;
    localparam int               APB_DATA_W    = 32;
    localparam logic             REG_DUTY_LIMIT = 1'b0;
    localparam logic             REG_TIMEOUT    = 1'b1;

    // Characters of the command format
    localparam logic [7:0] CHAR_X       = 8'h78;
    localparam logic [7:0] CHAR_Y       = 8'h79;
    localparam logic [7:0] CHAR_Z       = 8'h7A;
    localparam logic [7:0] CHAR_W       = 8'h77;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_DIG0    = 8'h30;
    localparam logic [7:0] CHAR_DIG9    = 8'h39;
    localparam logic [7:0] CHAR_HEXA    = 8'h61;
    localparam logic [7:0] CHAR_HEXF    = 8'h66;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] override_mask;
        logic [DUTY_W-1:0] duty_zero;
        logic [DUTY_W-1:0] duty_one;
        logic [DUTY_W-1:0] duty_two;
        logic [DUTY_W-1:0] duty_three;
        logic              command_applied;
        logic              format_error;
        logic              brake_applied;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_PARSE,
        OP_ERROR,
        OP_APPLY
    } t_op_kind;

    // One classified item on its way from parser to executor
    typedef struct packed {
        t_op_kind          kind;
        logic [CH_W-1:0]   chan;
        logic              rev;
        logic [PROD_W-1:0] product;
    } t_op;

endpackage

// ===== rtl/serial_motor_command_parser.sv =====
// Top level: serial motor command parser with APB registers; uses smcp_pkg.
// An accepted item is queued, then popped into the result register when it is free.
// Throughput: one item per cycle; a two-entry queue parts parser and executor,
// so the input stalls only once two items wait behind a stalled result.
// Reset (synchronous, active low) clears parser, overrides, duties, tick count
// and queue, and loads duty_limit=480, timeout_ticks=524.
`timescale 1ns / 1ps

module serial_motor_command_parser
    import smcp_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // result item channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [DUTY_W-1:0] r_duty_limit;
    logic [TICK_W-1:0] r_timeout_ticks;

    logic              in_accept;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    t_op               front_op;
    t_op               q_head;

    // Registers: index lives in paddr[2], low address bits are ignored
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_limit    <= DUTY_LIMIT_RESET;
            r_timeout_ticks <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_DUTY_LIMIT: r_duty_limit    <= pwdata[DUTY_W-1:0];
                REG_TIMEOUT:    r_timeout_ticks <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DUTY_LIMIT: prdata = APB_DATA_W'(r_duty_limit);
            REG_TIMEOUT:    prdata = APB_DATA_W'(r_timeout_ticks);
            default:        prdata = '0;
        endcase
    end

    // An item is taken whenever the queue has room; every item, tick or
    // byte, becomes one queue entry and later exactly one result item.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    smcp_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_in_item),
        .i_duty_limit (r_duty_limit),
        .o_op         (front_op)
    );

    smcp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (in_accept),
        .i_push_op (front_op),
        .o_full    (q_full),
        .i_pop     (q_pop),
        .o_valid   (q_valid),
        .o_head    (q_head)
    );

    // Back end pops while its result register is free or being drained
    smcp_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_duty_limit    (r_duty_limit),
        .i_timeout_ticks (r_timeout_ticks),
        .i_head_valid    (q_valid),
        .i_head          (q_head),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_item      (o_out_item)
    );

endmodule

// ===== rtl/smcp_queue.sv =====
// Two-entry queue of classified items between parser and executor.
// Depends on smcp_pkg.
`timescale 1ns / 1ps

module smcp_queue
    import smcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_push_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_head
);

    t_op                r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

// ===== rtl/smcp_front.sv =====
// Parser front end: accepts items, tracks the five-byte command format
// and classifies each item into a queue entry. Depends on smcp_pkg.
`timescale 1ns / 1ps

module smcp_front
    import smcp_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_in_item          i_item,
    input  logic [DUTY_W-1:0] i_duty_limit,
    output t_op               o_op
);

    typedef enum logic [2:0] {
        POS_CHAN,
        POS_SIGN,
        POS_HI,
        POS_LO,
        POS_NL
    } t_pos;

    t_pos               r_pos,   n_pos;
    logic [CH_W-1:0]    r_chan,  n_chan;
    logic               r_rev,   n_rev;
    logic [SPEED_W-1:0] r_speed, n_speed;

    logic [2:0]         letter_idx;   // 4 = not a channel letter
    logic               letter_ok;
    logic [3:0]         hex_val;
    logic               hex_ok;
    t_op_kind           kind;

    always_comb begin
        case (i_item.rx_byte)
            CHAR_X:  letter_idx = 3'd0;
            CHAR_Y:  letter_idx = 3'd1;
            CHAR_Z:  letter_idx = 3'd2;
            CHAR_W:  letter_idx = 3'd3;
            default: letter_idx = 3'd4;
        endcase
        letter_ok = (letter_idx < 3'(CHANNELS));
    end

    always_comb begin
        case (i_item.rx_byte) inside
            [CHAR_DIG0:CHAR_DIG9]: begin
                hex_val = i_item.rx_byte[3:0];
                hex_ok  = 1'b1;
            end
            [CHAR_HEXA:CHAR_HEXF]: begin
                hex_val = i_item.rx_byte[3:0] + 4'd9;
                hex_ok  = 1'b1;
            end
            default: begin
                hex_val = '0;
                hex_ok  = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_pos   = r_pos;
        n_chan  = r_chan;
        n_rev   = r_rev;
        n_speed = r_speed;
        kind    = OP_TICK;
        if (i_item.mode == MODE_BYTE) begin
            kind = OP_ERROR;
            case (r_pos)
                POS_CHAN: begin
                    if (letter_ok) begin
                        n_chan = letter_idx[CH_W-1:0];
                        n_pos  = POS_SIGN;
                        kind   = OP_PARSE;
                    end
                end
                POS_SIGN: begin
                    if (i_item.rx_byte == CHAR_PLUS || i_item.rx_byte == CHAR_MINUS) begin
                        n_rev = (i_item.rx_byte == CHAR_MINUS);
                        n_pos = POS_HI;
                        kind  = OP_PARSE;
                    end
                end
                POS_HI: begin
                    if (hex_ok) begin
                        n_speed = {hex_val, 4'h0};
                        n_pos   = POS_LO;
                        kind    = OP_PARSE;
                    end
                end
                POS_LO: begin
                    if (hex_ok) begin
                        n_speed = {r_speed[7:4], hex_val};
                        n_pos   = POS_NL;
                        kind    = OP_PARSE;
                    end
                end
                POS_NL: begin
                    if (i_item.rx_byte == CHAR_NEWLINE) begin
                        n_pos = POS_CHAN;
                        kind  = OP_APPLY;
                    end
                end
                default: kind = OP_ERROR;
            endcase
            if (kind == OP_ERROR) begin
                n_pos = POS_CHAN;
            end
        end
    end

    // Product is taken with the latched speed; the divide by 255 is in the back end
    always_comb begin
        o_op.kind    = kind;
        o_op.chan    = r_chan;
        o_op.rev     = r_rev;
        o_op.product = PROD_W'(r_speed) * PROD_W'(i_duty_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_CHAN;
            r_chan  <= '0;
            r_rev   <= 1'b0;
            r_speed <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_chan  <= n_chan;
            r_rev   <= n_rev;
            r_speed <= n_speed;
        end
    end

endmodule

// ===== rtl/smcp_back.sv =====
// Executor back end: applies queued items to duties, pin overrides and the
// idle tick counter, and holds the result register. Depends on smcp_pkg.
`timescale 1ns / 1ps

module smcp_back
    import smcp_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DUTY_W-1:0] i_duty_limit,
    input  logic [TICK_W-1:0] i_timeout_ticks,
    input  logic              i_head_valid,
    input  t_op               i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    logic [MASK_W-1:0] r_override, n_override;
    logic [DUTY_W-1:0] r_duty [CHANNELS];
    logic [DUTY_W-1:0] n_duty [CHANNELS];
    logic [TICK_W-1:0] r_idle, n_idle;
    logic              r_out_valid;
    t_out_item         r_out_item, n_out_item;

    logic [TICK_W-1:0] tick_next;
    logic [26:0]       scaled;
    logic [10:0]       q_est;
    logic [PROD_W:0]   q_back;
    logic [PROD_W:0]   remainder;
    logic [10:0]       quotient;
    logic [DUTY_W-1:0] duty_new;
    logic [DUTY_W-1:0] duty_all [MAX_CHANNELS];
    logic              applied, error, brake;

    assign o_pop       = i_head_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // floor(x/255): x*257/65536 is exact or one low, fixed by one compare
    always_comb begin
        scaled    = 27'(i_head.product) + (27'(i_head.product) << 8);
        q_est     = scaled[26:16];
        q_back    = (19'(q_est) << 8) - 19'(q_est);
        remainder = 19'(i_head.product) - q_back;
        quotient  = q_est + ((remainder >= 19'd255) ? 11'd1 : 11'd0);
        duty_new  = (quotient > 11'(i_duty_limit)) ? i_duty_limit : quotient[DUTY_W-1:0];
    end

    always_comb begin
        tick_next  = r_idle + 1'b1;
        n_override = r_override;
        n_idle     = r_idle;
        applied    = 1'b0;
        error      = 1'b0;
        brake      = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            n_duty[i] = r_duty[i];
        end
        case (i_head.kind)
            OP_TICK: begin
                if (tick_next >= i_timeout_ticks) begin
                    n_override = '0;
                    n_idle     = '0;
                    brake      = 1'b1;
                end else begin
                    n_idle = tick_next;
                end
            end
            OP_ERROR: error = 1'b1;
            OP_APPLY: begin
                applied = 1'b1;
                n_idle  = '0;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (i_head.chan == CH_W'(i)) begin
                        n_duty[i]         = duty_new;
                        n_override[2*i]   = i_head.rev;
                        n_override[2*i+1] = !i_head.rev;
                    end
                end
            end
            default: ;
        endcase

        for (int i = 0; i < MAX_CHANNELS; i++) begin
            duty_all[i] = '0;
        end
        for (int i = 0; i < CHANNELS; i++) begin
            duty_all[i] = n_duty[i];
        end
        n_out_item.override_mask   = n_override;
        n_out_item.duty_zero       = duty_all[0];
        n_out_item.duty_one        = duty_all[1];
        n_out_item.duty_two        = duty_all[2];
        n_out_item.duty_three      = duty_all[3];
        n_out_item.command_applied = applied;
        n_out_item.format_error    = error;
        n_out_item.brake_applied   = brake;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_override  <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_duty[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_override  <= n_override;
                r_idle      <= n_idle;
                r_out_valid <= 1'b1;
                for (int i = 0; i < CHANNELS; i++) begin
                    r_duty[i] <= n_duty[i];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item <= n_out_item;
        end
    end

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out_item.command_applied, r_out_item.format_error,
                                  r_out_item.brake_applied}))
        else $error("more than one status flag in a result");

    a_brake_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.brake_applied) |-> (r_out_item.override_mask == '0))
        else $error("brake result with overrides still set");

    a_apply_resets_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.kind == OP_APPLY) |=> (r_idle == '0))
        else $error("idle count not cleared by command");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for serial_motor_command_parser: directed table, then random
// command streams under several register settings and idle profiles.
// Depends on rtl/smcp_pkg.sv and rtl/serial_motor_command_parser.sv.
`timescale 1ns / 1ps

module testbench;
    import smcp_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no item moving
    localparam int          REPORT_LIMIT   = 10;    // mismatches printed in full
    localparam int          PHASE_ITEMS    = 120;   // random items per register phase
    localparam int          NUM_PHASES     = 6;
    localparam int          SPEED_FULL     = 255;   // speed byte that maps to the limit
    localparam logic [1:0]  PAIR_FWD       = 2'b10; // forward: low pin off, high pin on
    localparam logic [1:0]  PAIR_REV       = 2'b01; // reverse: the opposite
    // command parse positions
    localparam logic [2:0]  POS_LETTER     = 3'd0;
    localparam logic [2:0]  POS_SIGN       = 3'd1;
    localparam logic [2:0]  POS_HIGH       = 3'd2;
    localparam logic [2:0]  POS_LOW        = 3'd3;
    localparam logic [2:0]  POS_END        = 3'd4;

    // one row of the directed table; want is used only when known is set
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       known;
        t_out_item  want;
    } t_stim_row;

    // ------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // expectation typed into the table travels alongside the item
    logic      row_known  = 1'b0;
    t_out_item row_expect = '0;

    // idle profile of the current phase, percent per cycle
    int send_idle_pct = 0;
    int out_stall_pct = 0;

    int unsigned items_sent   = 0;
    int unsigned fails        = 0;
    int unsigned quiet_cycles = 0;

    t_out_item expected_results[$];

    // ------------------------------------------------------------------
    // Predictor state: parser latches, pin overrides, duties, tick count
    // and its own copy of the two registers
    // ------------------------------------------------------------------
    logic [2:0]        parse_pos      = POS_LETTER;
    logic [CH_W-1:0]   chan_held      = '0;
    logic              rev_held       = 1'b0;
    logic [7:0]        speed_held     = '0;
    logic [MASK_W-1:0] pin_mask       = '0;
    logic [DUTY_W-1:0] duty_now [MAX_CHANNELS] = '{default: '0};
    logic [TICK_W-1:0] tick_count     = '0;
    logic [DUTY_W-1:0] duty_limit_reg = DUTY_LIMIT_RESET;
    logic [TICK_W-1:0] timeout_reg    = TIMEOUT_RESET;

    serial_motor_command_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stall, redrawn every cycle from the phase's profile.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // ------------------------------------------------------------------
    // Predictor: advances the parser/brake state by one item and returns
    // the result the block should produce for it.
    // ------------------------------------------------------------------
    function automatic t_out_item step_motor_model(t_in_item it);
        t_out_item         res;
        logic              ok;
        logic [2:0]        pos;
        logic [TICK_W-1:0] next_count;
        logic [3:0]        nib;
        int                ch_idx;
        int unsigned       scaled;

        res = '0;
        if (it.mode == MODE_TICK) begin
            next_count = tick_count + 16'd1;
            // a timeout of zero behaves like one; lowering it brakes at once
            if (next_count >= timeout_reg) begin
                pin_mask          = '0;
                tick_count        = '0;
                res.brake_applied = 1'b1;
            end else begin
                tick_count = next_count;
            end
        end else begin
            ok  = 1'b1;
            nib = '0;
            pos = (parse_pos > POS_END) ? POS_LETTER : parse_pos;
            case (pos)
                POS_LETTER: begin
                    case (it.rx_byte)
                        CHAR_X:  ch_idx = 0;
                        CHAR_Y:  ch_idx = 1;
                        CHAR_Z:  ch_idx = 2;
                        CHAR_W:  ch_idx = 3;
                        default: ch_idx = MAX_CHANNELS;
                    endcase
                    // a letter for a channel that is not fitted is a bad byte
                    if (ch_idx < DEFAULT_CHANNELS) chan_held = ch_idx[CH_W-1:0];
                    else ok = 1'b0;
                end
                POS_SIGN: begin
                    if (it.rx_byte == CHAR_PLUS) rev_held = 1'b0;
                    else if (it.rx_byte == CHAR_MINUS) rev_held = 1'b1;
                    else ok = 1'b0;
                end
                POS_HIGH, POS_LOW: begin
                    // lower-case hex only
                    if (it.rx_byte >= CHAR_DIG0 && it.rx_byte <= CHAR_DIG9)
                        nib = 4'(it.rx_byte - CHAR_DIG0);
                    else if (it.rx_byte >= CHAR_HEXA && it.rx_byte <= CHAR_HEXF)
                        nib = 4'(it.rx_byte - CHAR_HEXA + 8'd10);
                    else
                        ok = 1'b0;
                    if (ok && pos == POS_HIGH) speed_held = {nib, 4'h0};
                    else if (ok) speed_held = {speed_held[7:4], nib};
                end
                default: begin
                    if (it.rx_byte != CHAR_NEWLINE) ok = 1'b0;
                end
            endcase

            if (!ok) begin
                // bad byte is dropped, not reused as a first byte
                res.format_error = 1'b1;
                parse_pos        = POS_LETTER;
            end else if (pos == POS_END) begin
                scaled = (32'(speed_held) * 32'(duty_limit_reg)) / SPEED_FULL;
                if (scaled > duty_limit_reg) scaled = duty_limit_reg;
                duty_now[chan_held]          = scaled[DUTY_W-1:0];
                pin_mask[2*chan_held +: 2]   = rev_held ? PAIR_REV : PAIR_FWD;
                tick_count                   = '0;
                res.command_applied          = 1'b1;
                parse_pos                    = POS_LETTER;
            end else begin
                parse_pos = pos + 3'd1;
            end
        end
        res.override_mask = pin_mask;
        res.duty_zero     = duty_now[0];
        res.duty_one      = duty_now[1];
        res.duty_two      = duty_now[2];
        res.duty_three    = duty_now[3];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: mirrors register writes, predicts on every accepted item,
    // checks every accepted result against the oldest expectation.
    // All handshake signals are driven by NBA, so values read here are the
    // ones the DUT saw at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_TIMEOUT) timeout_reg = pwdata[TICK_W-1:0];
                else duty_limit_reg = pwdata[DUTY_W-1:0];
            end

            if (i_in_valid && !o_in_stall) begin
                want = step_motor_model(i_in_item);
                // table rows with a typed result are held to that value
                if (row_known) want = row_expect;
                expected_results.push_back(want);
            end

            if (o_out_valid && !i_out_stall) begin
                got = o_out_item;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: result with nothing expected: mask=%h", $realtime,
                                 got.override_mask);
                end else begin
                    want = expected_results.pop_front();
                    if (got.override_mask   !== want.override_mask   ||
                        got.duty_zero       !== want.duty_zero       ||
                        got.duty_one        !== want.duty_one        ||
                        got.duty_two        !== want.duty_two        ||
                        got.duty_three      !== want.duty_three      ||
                        got.command_applied !== want.command_applied ||
                        got.format_error    !== want.format_error    ||
                        got.brake_applied   !== want.brake_applied) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: mismatch mask/d0/d1/d2/d3/app/err/brk", $realtime);
                            $display("  expected %h %0d %0d %0d %0d %b %b %b",
                                     want.override_mask, want.duty_zero, want.duty_one,
                                     want.duty_two, want.duty_three, want.command_applied,
                                     want.format_error, want.brake_applied);
                            $display("  actual   %h %0d %0d %0d %0d %b %b %b",
                                     got.override_mask, got.duty_zero, got.duty_one,
                                     got.duty_two, got.duty_three, got.command_applied,
                                     got.format_error, got.brake_applied);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: too long without any item moving ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one item and hold it until accepted. Valid stays high on
    // return so back-to-back items need no extra NBA in the same step.
    task automatic send_item(input logic mode, input logic [7:0] rx,
                             input logic known, input t_out_item want);
        t_in_item it;
        it.mode    = mode;
        it.rx_byte = rx;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        row_known  <= known;
        row_expect <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(MODE_BYTE, rx, 1'b0, '0);
    endtask

    // Lower valid and wait until every expected result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access until pready, then one idle cycle.
    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // First `count` bytes of a random well-formed command, ticks mixed in.
    task automatic send_command_prefix(input int count);
        logic [7:0] cmd [5];
        int         h;
        case ($urandom_range(3))
            0:       cmd[0] = CHAR_X;
            1:       cmd[0] = CHAR_Y;
            2:       cmd[0] = CHAR_Z;
            default: cmd[0] = CHAR_W;
        endcase
        cmd[1] = $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS;
        for (int k = 2; k < 4; k++) begin
            h      = $urandom_range(15);
            cmd[k] = (h < 10) ? CHAR_DIG0 + 8'(h) : CHAR_HEXA + 8'(h - 10);
        end
        cmd[4] = CHAR_NEWLINE;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 20) send_tick();
            send_byte(cmd[k]);
        end
    endtask

    // Mostly complete commands; the rest tick runs, noise and cut-off commands.
    task automatic run_random(input int unsigned stop_at);
        int pick;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                send_command_prefix(5);
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 8)) send_tick();
            end else if (pick < 85) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_command_prefix($urandom_range(1, 4));
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    function automatic t_stim_row stim_row(input logic mode, input logic [7:0] rx,
                                           input logic known, input t_out_item want);
        t_stim_row r;
        r.mode    = mode;
        r.rx_byte = rx;
        r.known   = known;
        r.want    = want;
        return r;
    endfunction

    // Result with channels 1 and 2 at zero duty, as in the directed part.
    function automatic t_out_item typed_result(input logic [7:0] mask,
                                               input logic [9:0] d0, input logic [9:0] d3,
                                               input logic app, input logic err);
        t_out_item r;
        r                 = '0;
        r.override_mask   = mask;
        r.duty_zero       = d0;
        r.duty_three      = d3;
        r.command_applied = app;
        r.format_error    = err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_stim_row       directed[$];
        logic [9:0]      limits   [NUM_PHASES];
        logic [15:0]     timeouts [NUM_PHASES];

        // Directed table, reset registers (limit 480, timeout 524).
        // tick straight after reset: no overrides, no flags
        directed.push_back(stim_row(MODE_TICK, 8'hFF, 1'b1,
                                    typed_result(8'h00, 10'd0, 10'd0, 1'b0, 1'b0)));
        // x+ff: full speed gives the limit itself, channel 0 forward
        directed.push_back(stim_row(MODE_BYTE, CHAR_X, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_PLUS, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_HEXF, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_HEXF, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_NEWLINE, 1'b1,
                                    typed_result(8'h02, 10'd480, 10'd0, 1'b1, 1'b0)));
        // w-00: zero speed, channel 3 reverse
        directed.push_back(stim_row(MODE_BYTE, CHAR_W, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_MINUS, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_DIG0, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_DIG0, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_NEWLINE, 1'b1,
                                    typed_result(8'h42, 10'd480, 10'd0, 1'b1, 1'b0)));
        // bad letter
        directed.push_back(stim_row(MODE_BYTE, 8'hFF, 1'b1,
                                    typed_result(8'h42, 10'd480, 10'd0, 1'b0, 1'b1)));
        // bad sign
        directed.push_back(stim_row(MODE_BYTE, CHAR_Y, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, 8'h00, 1'b1,
                                    typed_result(8'h42, 10'd480, 10'd0, 1'b0, 1'b1)));
        // bad newline after a good z-9a
        directed.push_back(stim_row(MODE_BYTE, CHAR_Z, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_MINUS, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_DIG9, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_HEXA, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, 8'h20, 1'b1,
                                    typed_result(8'h42, 10'd480, 10'd0, 1'b0, 1'b1)));
        // bad hex digit ('g', just past 'f')
        directed.push_back(stim_row(MODE_BYTE, CHAR_Y, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_PLUS, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_HEXF + 8'd1, 1'b1,
                                    typed_result(8'h42, 10'd480, 10'd0, 1'b0, 1'b1)));
        // y+80 then two ticks: mid-scale duty, tick count restarts
        directed.push_back(stim_row(MODE_BYTE, CHAR_Y, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_PLUS, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, 8'h38, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_DIG0, 1'b0, '0));
        directed.push_back(stim_row(MODE_BYTE, CHAR_NEWLINE, 1'b0, '0));
        directed.push_back(stim_row(MODE_TICK, 8'h00, 1'b0, '0));
        directed.push_back(stim_row(MODE_TICK, 8'h00, 1'b0, '0));

        // Register settings per phase; extremes first, then mixed values.
        // The timeout steps down from 40 to 2 so the count lies above it.
        limits   = '{10'd1023, 10'd0, 10'd255, 10'($urandom_range(1, 1022)), 10'd1,
                     10'($urandom_range(1023))};
        timeouts = '{16'd65535, 16'd1, 16'd0, 16'd5, 16'd40, 16'd2};

        // Reset is held from time zero, then released on an edge.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_item(directed[k].mode, directed[k].rx_byte, directed[k].known,
                      directed[k].want);

        // Random phases: registers change only once the block is drained,
        // which also gives the sender a full pause each time.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            case (ph % 4)
                0: begin send_idle_pct <= 0;  out_stall_pct <= 0;  end
                1: begin send_idle_pct <= 48; out_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  out_stall_pct <= 48; end
                default: begin send_idle_pct <= 8; out_stall_pct <= 8; end
            endcase
            write_reg(REG_DUTY_LIMIT, {22'($urandom), limits[ph]});
            write_reg(REG_TIMEOUT, {16'($urandom), timeouts[ph]});
            @(posedge i_clk);
            run_random(items_sent + PHASE_ITEMS);
            // trailing ticks leave a count behind for the next setting
            repeat ($urandom_range(3, 12)) send_tick();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fails == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
